@@ rtl/fir_filter_loadable_taps_unit_macros.svh @@
// assertion macros used by the checker file of the fir filter unit
`ifndef FIR_FILTER_LOADABLE_TAPS_UNIT_MACROS_SVH
`define FIR_FILTER_LOADABLE_TAPS_UNIT_MACROS_SVH

// same-cycle implication, sampled on clock, quiet during reset
`define FIRLT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fir filter check failed");

// next-cycle implication, sampled on clock, quiet during reset
`define FIRLT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fir filter check failed");

`endif

@@ rtl/firlt_pkg.sv @@
// shared constants and types of the loadable-tap fir filter
`default_nettype none
package firlt_pkg;

   // filter geometry
   localparam int MAX_TAPS = 128;
   localparam int TAP_AW   = $clog2(MAX_TAPS);
   localparam int TAPS_W   = 8;
   localparam int DATA_W   = 16;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int ACC_W    = 40;
   localparam int FRAC_W   = DATA_W - 1;

   // transaction commands
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   // one read beat travelling from the sequencer to the mac
   typedef struct packed {
      logic valid;
      logic last;
      logic coef_ok;
      logic dly_ok;
   } mac_ctrl_type;

endpackage
`default_nettype wire

@@ rtl/firlt_ram.sv @@
// generic single-write, single-read memory with registered read data
`default_nettype none
module firlt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ rtl/firlt_ctrl.sv @@
// sequencer: command decode, delay line pointer, entry valid bits and tap walk
`default_nettype none
module firlt_ctrl (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic [1:0]                           req_command,
   input  wire logic [firlt_pkg::TAP_AW-1:0]         req_coef_index,
   input  wire logic [firlt_pkg::TAPS_W-1:0]         tap_count,
   input  wire logic                                 out_free,
   input  wire logic                                 mac_done,
   output      logic                                 coef_we,
   output      logic [firlt_pkg::TAP_AW-1:0]         coef_raddr,
   output      logic                                 dly_we,
   output      logic [firlt_pkg::TAP_AW-1:0]         dly_waddr,
   output      logic [firlt_pkg::TAP_AW-1:0]         dly_raddr,
   output      logic                                 acc_clear,
   output      firlt_pkg::mac_ctrl_type              mac_ctrl,
   output      logic                                 out_load
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]                          state_ff, state_in;
   logic [firlt_pkg::TAP_AW-1:0]        cnt_ff, cnt_in;
   logic [firlt_pkg::TAP_AW-1:0]        newest_ff, newest_in;
   logic [firlt_pkg::MAX_TAPS-1:0]      coef_ok_ff, coef_ok_in;
   logic [firlt_pkg::MAX_TAPS-1:0]      dly_ok_ff, dly_ok_in;
   firlt_pkg::mac_ctrl_type             s1_ff, s1_in;
   logic [firlt_pkg::TAPS_W-1:0]        taps_eff;
   logic [firlt_pkg::TAP_AW-1:0]        slot;
   logic                                accept;
   logic                                issue;
   logic                                last_issue;

   // taps in use, clipped to the store depth
   assign taps_eff = (tap_count > firlt_pkg::TAPS_W'(firlt_pkg::MAX_TAPS)) ?
                     firlt_pkg::TAPS_W'(firlt_pkg::MAX_TAPS) : tap_count;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign slot       = newest_ff + firlt_pkg::TAP_AW'(1);
   assign last_issue = (firlt_pkg::TAPS_W'(cnt_ff) == taps_eff - firlt_pkg::TAPS_W'(1));

   // read addresses walk coefficient i against sample k-i
   assign coef_raddr = cnt_ff;
   assign dly_raddr  = newest_ff - cnt_ff;
   assign dly_waddr  = slot;

   // next-state logic
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      newest_in  = newest_ff;
      coef_ok_in = coef_ok_ff;
      dly_ok_in  = dly_ok_ff;
      coef_we    = 1'b0;
      dly_we     = 1'b0;
      acc_clear  = 1'b0;
      out_load   = 1'b0;
      issue      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  firlt_pkg::CMD_LOAD: begin
                     coef_we                    = 1'b1;
                     coef_ok_in[req_coef_index] = 1'b1;
                  end
                  firlt_pkg::CMD_CLEAR: begin
                     dly_ok_in = '0;
                  end
                  firlt_pkg::CMD_SAMPLE: begin
                     dly_we          = 1'b1;
                     dly_ok_in[slot] = 1'b1;
                     newest_in       = slot;
                     acc_clear       = 1'b1;
                     cnt_in          = '0;
                     state_in        = (taps_eff == '0) ? ST_DONE : ST_RUN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            issue  = 1'b1;
            cnt_in = cnt_ff + firlt_pkg::TAP_AW'(1);
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // beat that lines up with the memory read data
   always_comb begin
      s1_in.valid   = issue;
      s1_in.last    = issue && last_issue;
      s1_in.coef_ok = coef_ok_ff[coef_raddr];
      s1_in.dly_ok  = dly_ok_ff[dly_raddr];
   end

   assign mac_ctrl = s1_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         newest_ff  <= '0;
         coef_ok_ff <= '0;
         dly_ok_ff  <= '0;
         s1_ff      <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         newest_ff  <= newest_in;
         coef_ok_ff <= coef_ok_in;
         dly_ok_ff  <= dly_ok_in;
         s1_ff      <= s1_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/firlt_mac.sv @@
// multiply-accumulate datapath with round half up and saturation to q1.15
`default_nettype none
module firlt_mac (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                acc_clear,
   input  wire firlt_pkg::mac_ctrl_type             mac_ctrl,
   input  wire logic [firlt_pkg::DATA_W-1:0]        coef_rdata,
   input  wire logic [firlt_pkg::DATA_W-1:0]        dly_rdata,
   output      logic                                mac_done,
   output      logic signed [firlt_pkg::DATA_W-1:0] filtered,
   output      logic                                saturated
);

   localparam int TOP_W = firlt_pkg::ACC_W - 2 * firlt_pkg::FRAC_W;

   logic signed [firlt_pkg::DATA_W-1:0] op_a;
   logic signed [firlt_pkg::DATA_W-1:0] op_b;
   logic signed [firlt_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                                p_valid_ff;
   logic                                p_last_ff;
   logic signed [firlt_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic                                done_ff;
   logic signed [firlt_pkg::ACC_W-1:0]  rnd;
   logic [TOP_W-2:0]                    rnd_top;
   logic                                pos_over;
   logic                                neg_over;

   // entries never written read as zero
   assign op_a    = mac_ctrl.coef_ok ? signed'(coef_rdata) : '0;
   assign op_b    = mac_ctrl.dly_ok  ? signed'(dly_rdata)  : '0;
   assign prod_in = op_a * op_b;

   // product stage
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         p_last_ff  <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         p_valid_ff <= mac_ctrl.valid;
         p_last_ff  <= mac_ctrl.last;
         done_ff    <= p_valid_ff && p_last_ff;
      end
   end

   // accumulator
   always_comb begin
      acc_in = acc_ff;
      if (acc_clear) begin
         acc_in = '0;
      end else if (p_valid_ff) begin
         acc_in = acc_ff + {{(firlt_pkg::ACC_W - firlt_pkg::PROD_W){prod_ff[firlt_pkg::PROD_W-1]}},
                            prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign mac_done = done_ff;

   // round half up, then clip when the upper bits are not a sign extension
   assign rnd      = acc_ff + firlt_pkg::ACC_W'(1 << (firlt_pkg::FRAC_W - 1));
   assign rnd_top  = rnd[firlt_pkg::ACC_W-2:2*firlt_pkg::FRAC_W];
   assign pos_over = !rnd[firlt_pkg::ACC_W-1] && (rnd_top != '0);
   assign neg_over = rnd[firlt_pkg::ACC_W-1] && (rnd_top != '1);

   always_comb begin
      saturated = pos_over || neg_over;
      if (pos_over) begin
         filtered = {1'b0, {(firlt_pkg::DATA_W-1){1'b1}}};
      end else if (neg_over) begin
         filtered = {1'b1, {(firlt_pkg::DATA_W-1){1'b0}}};
      end else begin
         filtered = rnd[2*firlt_pkg::FRAC_W:firlt_pkg::FRAC_W];
      end
   end

endmodule
`default_nettype wire

@@ rtl/fir_filter_loadable_taps_unit.sv @@
// top level of the loadable-tap fir filter
//
// Direct-form FIR filter with up to 128 loadable Q1.15 taps. A load transaction
// writes one coefficient and a clear transaction zeroes the delay line. A
// sample transaction shifts the sample into the delay line and returns
// y = sum h[i]*x[k-i], rounded half up and saturated to Q1.15 with a clip
// flag. Coefficients and samples sit in two single-port-read memories; one
// multiplier walks the taps at one tap per cycle, and the tap walk is followed
// by the memory read, product and accumulate stages. A new transaction is
// taken while a finished result waits on the response channel. After reset
// both stores read as zero; no clearing pass is needed.
`default_nettype none
module fir_filter_loadable_taps_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [1:0]                          req_command,
   input  wire logic [6:0]                          req_coef_index,
   input  wire logic signed [15:0]                  req_coef_value,
   input  wire logic signed [15:0]                  req_sample,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic signed [15:0]                  rsp_filtered,
   output      logic                                rsp_saturated,
   input  wire logic                                csr_write_enable,
   input  wire logic [7:0]                          csr_write_data
);

   logic [firlt_pkg::TAPS_W-1:0]        tap_count_ff, tap_count_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [firlt_pkg::DATA_W-1:0] rsp_filtered_ff;
   logic                                rsp_saturated_ff;
   logic                                out_free;
   logic                                out_load;
   logic                                mac_done;
   logic                                coef_we;
   logic [firlt_pkg::TAP_AW-1:0]        coef_raddr;
   logic                                dly_we;
   logic [firlt_pkg::TAP_AW-1:0]        dly_waddr;
   logic [firlt_pkg::TAP_AW-1:0]        dly_raddr;
   logic [firlt_pkg::DATA_W-1:0]        coef_rdata;
   logic [firlt_pkg::DATA_W-1:0]        dly_rdata;
   logic                                acc_clear;
   firlt_pkg::mac_ctrl_type             mac_ctrl;
   logic signed [firlt_pkg::DATA_W-1:0] filtered;
   logic                                saturated;

   // tap count register
   assign tap_count_in = csr_write_enable ? csr_write_data : tap_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= firlt_pkg::TAPS_W'(firlt_pkg::MAX_TAPS);
      end else begin
         tap_count_ff <= tap_count_in;
      end
   end

   // sequencer
   firlt_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_coef_index (req_coef_index),
      .tap_count      (tap_count_ff),
      .out_free       (out_free),
      .mac_done       (mac_done),
      .coef_we        (coef_we),
      .coef_raddr     (coef_raddr),
      .dly_we         (dly_we),
      .dly_waddr      (dly_waddr),
      .dly_raddr      (dly_raddr),
      .acc_clear      (acc_clear),
      .mac_ctrl       (mac_ctrl),
      .out_load       (out_load)
   );

   // coefficient store
   firlt_ram #(
      .WIDTH (firlt_pkg::DATA_W),
      .DEPTH (firlt_pkg::MAX_TAPS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (req_coef_index),
      .wr_data (req_coef_value),
      .rd_addr (coef_raddr),
      .rd_data (coef_rdata)
   );

   // delay line store
   firlt_ram #(
      .WIDTH (firlt_pkg::DATA_W),
      .DEPTH (firlt_pkg::MAX_TAPS)
   ) u_dly_ram (
      .clock   (clock),
      .wr_en   (dly_we),
      .wr_addr (dly_waddr),
      .wr_data (req_sample),
      .rd_addr (dly_raddr),
      .rd_data (dly_rdata)
   );

   // multiply-accumulate and output formatting
   firlt_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .acc_clear  (acc_clear),
      .mac_ctrl   (mac_ctrl),
      .coef_rdata (coef_rdata),
      .dly_rdata  (dly_rdata),
      .mac_done   (mac_done),
      .filtered   (filtered),
      .saturated  (saturated)
   );

   // response register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_filtered_ff  <= filtered;
         rsp_saturated_ff <= saturated;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filtered_ff;
   assign rsp_saturated = rsp_saturated_ff;

endmodule
`default_nettype wire

@@ rtl/firlt_checker.sv @@
// port-level checks of the fir filter unit and their binding
`default_nettype none
`include "fir_filter_loadable_taps_unit_macros.svh"
module firlt_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic [1:0]        req_command,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic signed [15:0] rsp_filtered,
   input wire logic              rsp_saturated
);

   // a waiting result holds
   `FIRLT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_filtered) && $stable(rsp_saturated))

   // the clip flag only comes with a full-scale value
   `FIRLT_ASSERT_NOW(a_sat_value, rsp_valid && rsp_saturated, (rsp_filtered == 16'sh7FFF) || (rsp_filtered == -16'sh8000))

   // a sample transaction leaves the block busy in the cycle after it is taken
   `FIRLT_ASSERT_NEXT(a_sample_busy, req_valid && req_ready && (req_command == firlt_pkg::CMD_SAMPLE), !req_ready)

   // a new result only appears at the end of a busy period
   `FIRLT_ASSERT_NOW(a_rsp_after_busy, $rose(rsp_valid), !$past(req_ready))

endmodule

bind fir_filter_loadable_taps_unit firlt_checker u_firlt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_command   (req_command),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_filtered  (rsp_filtered),
   .rsp_saturated (rsp_saturated)
);
`default_nettype wire
